[src/smau_pkg.sv]
package smau_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int ELEM_WIDTH_DEFAULT = 32;

   // Fixed port widths.
   localparam int VALUE_W     = 32;
   localparam int IDX_W       = 3;
   localparam int MODE_W      = 2;
   localparam int OP_W        = 3;
   localparam int SIZE_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // The multiplier works on chunks of this width.
   localparam int CHUNK_W = 32;

   // Transaction modes.
   localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RD_C    = 2'd3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
   localparam logic [OP_W-1:0] OP_NEG   = 3'd4;
   localparam logic [OP_W-1:0] OP_EQ    = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_OPERATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALAR    = 2'd2;

   localparam logic [OP_W-1:0]   OP_RESET   = OP_MUL;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_NEG
   } alu_sel_type;

   typedef enum logic [1:0] {
      CSRC_ALU,
      CSRC_PROD,
      CSRC_MAC
   } c_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        accept;
      logic        err;
      logic        rd_c;
      logic        wr_a;
      logic        wr_b;
      logic        rd_ab;
      logic        mac_addr;
      logic        c_clear;
      logic        c_wr;
      c_src_type   c_src;
      alu_sel_type alu_sel;
      logic        mul_start;
      logic        mul_scalar;
      logic        acc_clr;
      logic        acc_add;
      logic        eq_init;
      logic        eq_cmp;
      logic        eq_commit;
      logic        rsp_load;
   } smau_cmd_type;

   // Bits needed to index a store of the given depth.
   function automatic int idx_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[src/smau_mul.sv]
module smau_mul
   import smau_pkg::*;
#(
   parameter int W = ELEM_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic [W-1:0] prod
);

   // Product modulo 2**W, built from CHUNK_W x CHUNK_W partial products,
   // one per cycle, each registered before it is added in.
   localparam int NCH   = (W + CHUNK_W - 1) / CHUNK_W;
   localparam int PW    = NCH * CHUNK_W;
   localparam int NSTEP = NCH * NCH;
   localparam int CW    = idx_bits(NSTEP);
   localparam int SHW   = idx_bits(2 * NCH - 1);

   logic [PW-1:0]        a_ff, b_ff, acc_ff;
   logic [2*CHUNK_W-1:0] pp_ff;
   logic [SHW-1:0]       sh_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff, pp_vld_ff, last_ff, done_ff;

   logic [CW-1:0]        ci, cj;
   logic [CHUNK_W-1:0]   a_chunk, b_chunk;
   logic [2*PW-1:0]      pp_wide, pp_shift;

   assign ci       = CW'(cnt_ff / NCH);
   assign cj       = CW'(cnt_ff % NCH);
   assign a_chunk  = a_ff[CHUNK_W*ci +: CHUNK_W];
   assign b_chunk  = b_ff[CHUNK_W*cj +: CHUNK_W];
   assign pp_wide  = (2*PW)'(pp_ff);
   assign pp_shift = pp_wide << (CHUNK_W * sh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         last_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff   <= pp_vld_ff && last_ff;
         pp_vld_ff <= busy_ff;
         if (busy_ff) begin
            last_ff <= (cnt_ff == CW'(NSTEP - 1));
         end
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(NSTEP - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= PW'(a);
         b_ff   <= PW'(b);
         acc_ff <= '0;
      end else if (pp_vld_ff) begin
         acc_ff <= acc_ff + pp_shift[PW-1:0];
      end
      if (busy_ff) begin
         pp_ff <= a_chunk * b_chunk;
         sh_ff <= SHW'(ci) + SHW'(cj);
      end
   end

   assign done = done_ff;
   assign prod = acc_ff[W-1:0];

endmodule

[src/smau_datapath.sv]
module smau_datapath
   import smau_pkg::*;
#(
   parameter  int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter  int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
   localparam int IW         = idx_bits(MAX_DIM)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  smau_cmd_type                cmd,
   input  logic [IW-1:0]               idx_i,
   input  logic [IW-1:0]               idx_j,
   input  logic [IW-1:0]               idx_k,
   input  logic [IDX_W-1:0]            req_row,
   input  logic [IDX_W-1:0]            req_col,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output logic                        mul_done,
   output logic                        rsp_status,
   output logic signed [VALUE_W-1:0]   rsp_element,
   output logic                        rsp_equal
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int AW    = idx_bits(CELLS);
   localparam int EXTW  = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

   function automatic logic [AW-1:0] cell_addr(input int unsigned r, input int unsigned c);
      return AW'(r * MAX_DIM + c);
   endfunction

   // Element stores; a cleared valid bit makes an entry read as zero.
   logic [ELEM_WIDTH-1:0] mem_a_ff [CELLS];
   logic [ELEM_WIDTH-1:0] mem_b_ff [CELLS];
   logic [ELEM_WIDTH-1:0] mem_c_ff [CELLS];
   logic [CELLS-1:0]      va_ff, vb_ff, vc_ff;

   logic [ELEM_WIDTH-1:0] ra_ff, rb_ff, rc_ff, acc_ff;
   logic                  rav_ff, rbv_ff, rcv_ff;
   logic                  err_ff, rdsel_ff, same_ff, eq_flag_ff;
   logic signed [VALUE_W-1:0] scalar_ff;
   logic                  rsp_status_ff, rsp_equal_ff;
   logic [VALUE_W-1:0]    rsp_element_ff;

   logic [AW-1:0]         host_addr, a_addr, b_addr, c_addr;
   logic [ELEM_WIDTH-1:0] wr_data, scalar_w, a_op, b_op, alu, c_wdata, prod, mul_b;
   logic [VALUE_W-1:0]    c_word;

   assign host_addr = cell_addr(req_row, req_col);
   assign a_addr    = cmd.mac_addr ? cell_addr(idx_i, idx_k) : cell_addr(idx_i, idx_j);
   assign b_addr    = cmd.mac_addr ? cell_addr(idx_k, idx_j) : cell_addr(idx_i, idx_j);
   assign c_addr    = cell_addr(idx_i, idx_j);

   // Sign-extend the 32-bit values, then keep the element width; an element of C is zero-extended or cut to 32 bits.
   assign wr_data  = ELEM_WIDTH'(EXTW'(req_value));
   assign scalar_w = ELEM_WIDTH'(EXTW'(scalar_ff));
   assign c_word   = VALUE_W'(EXTW'(rc_ff));

   assign a_op  = rav_ff ? ra_ff : '0;
   assign b_op  = rbv_ff ? rb_ff : '0;
   assign mul_b = cmd.mul_scalar ? scalar_w : b_op;

   always_comb begin
      case (cmd.alu_sel)
         ALU_ADD: alu = a_op + b_op;
         ALU_SUB: alu = a_op - b_op;
         ALU_NEG: alu = '0 - a_op;
         default: alu = '0;
      endcase
   end

   always_comb begin
      case (cmd.c_src)
         CSRC_ALU:  c_wdata = alu;
         CSRC_PROD: c_wdata = prod;
         CSRC_MAC:  c_wdata = acc_ff + prod;
         default:   c_wdata = alu;
      endcase
   end

   smau_mul #(
      .W (ELEM_WIDTH)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (a_op),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a_ff[host_addr] <= wr_data;
      end
      if (cmd.wr_b) begin
         mem_b_ff[host_addr] <= wr_data;
      end
      if (cmd.c_wr) begin
         mem_c_ff[c_addr] <= c_wdata;
      end
      if (cmd.rd_ab) begin
         ra_ff  <= mem_a_ff[a_addr];
         rb_ff  <= mem_b_ff[b_addr];
         rav_ff <= va_ff[a_addr];
         rbv_ff <= vb_ff[b_addr];
      end
      if (cmd.rd_c) begin
         rc_ff  <= mem_c_ff[host_addr];
         rcv_ff <= vc_ff[host_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         err_ff   <= cmd.err;
         rdsel_ff <= cmd.rd_c;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod;
      end
      if (cmd.eq_init) begin
         same_ff <= 1'b1;
      end else if (cmd.eq_cmp && (a_op != b_op)) begin
         same_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= err_ff;
         rsp_element_ff <= (rdsel_ff && rcv_ff) ? c_word : '0;
         rsp_equal_ff   <= eq_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff      <= '0;
         vb_ff      <= '0;
         vc_ff      <= '0;
         eq_flag_ff <= 1'b0;
         scalar_ff  <= '0;
      end else begin
         if (cmd.wr_a) begin
            va_ff[host_addr] <= 1'b1;
         end
         if (cmd.wr_b) begin
            vb_ff[host_addr] <= 1'b1;
         end
         if (cmd.c_clear) begin
            vc_ff <= '0;
         end else if (cmd.c_wr) begin
            vc_ff[c_addr] <= 1'b1;
         end
         if (cmd.eq_commit) begin
            eq_flag_ff <= same_ff;
         end
         if (csr_wr_en && (csr_index == CSR_SCALAR)) begin
            scalar_ff <= signed'(csr_wdata);
         end
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_element = signed'(rsp_element_ff);
   assign rsp_equal   = rsp_equal_ff;

endmodule

[src/smau_ctrl.sv]
module smau_ctrl
   import smau_pkg::*;
#(
   parameter  int MAX_DIM = MAX_DIM_DEFAULT,
   localparam int IW      = idx_bits(MAX_DIM)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [IDX_W-1:0]       req_row,
   input  logic [IDX_W-1:0]       req_col,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   mul_done,
   output smau_cmd_type           cmd,
   output logic [IW-1:0]          idx_i,
   output logic [IW-1:0]          idx_j,
   output logic [IW-1:0]          idx_k
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_OPER,
      ST_MULW,
      ST_FIN,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SIZE_W-1:0] dim, n_last;
   logic              accept, in_range, slot_free, last_i, last_j, last_k, adv;

   // A size of zero acts as one; sizes above the store act as the store.
   always_comb begin
      if (size_ff == '0) begin
         dim = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         dim = SIZE_W'(MAX_DIM);
      end else begin
         dim = size_ff;
      end
   end

   assign n_last    = dim - SIZE_W'(1);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign in_range  = (SIZE_W'(req_row) < dim) && (SIZE_W'(req_col) < dim);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_i    = (SIZE_W'(i_ff) == n_last);
   assign last_j    = (SIZE_W'(j_ff) == n_last);
   assign last_k    = (SIZE_W'(k_ff) == n_last);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      adv          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_in        = op_ff;
      size_in      = size_ff;

      if (csr_wr_en && (csr_index == CSR_OPERATION)) begin
         op_in = csr_wdata[OP_W-1:0];
      end
      if (csr_wr_en && (csr_index == CSR_SIZE)) begin
         size_in = csr_wdata[SIZE_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               cmd.err    = (req_mode != MODE_COMPUTE) && !in_range;
               cmd.wr_a   = (req_mode == MODE_WR_A) && in_range;
               cmd.wr_b   = (req_mode == MODE_WR_B) && in_range;
               cmd.rd_c   = (req_mode == MODE_RD_C) && in_range;
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               state_in   = ST_RESP;
               if (req_mode == MODE_COMPUTE) begin
                  case (op_ff) inside
                     OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_NEG: begin
                        cmd.c_clear = 1'b1;
                        state_in    = ST_RD;
                     end
                     OP_EQ: begin
                        cmd.eq_init = 1'b1;
                        state_in    = ST_RD;
                     end
                     default: state_in = ST_RESP;
                  endcase
               end
            end
         end
         ST_RD: begin
            cmd.rd_ab    = 1'b1;
            cmd.mac_addr = (op_ff == OP_MUL);
            cmd.acc_clr  = (k_ff == '0);
            state_in     = ST_OPER;
         end
         ST_OPER: begin
            case (op_ff) inside
               OP_EQ: begin
                  cmd.eq_cmp = 1'b1;
                  adv        = 1'b1;
               end
               OP_MUL, OP_SCALE: begin
                  cmd.mul_start  = 1'b1;
                  cmd.mul_scalar = (op_ff == OP_SCALE);
                  state_in       = ST_MULW;
               end
               OP_ADD: begin
                  cmd.c_wr    = 1'b1;
                  cmd.alu_sel = ALU_ADD;
                  adv         = 1'b1;
               end
               OP_SUB: begin
                  cmd.c_wr    = 1'b1;
                  cmd.alu_sel = ALU_SUB;
                  adv         = 1'b1;
               end
               OP_NEG: begin
                  cmd.c_wr    = 1'b1;
                  cmd.alu_sel = ALU_NEG;
                  adv         = 1'b1;
               end
               default: adv = 1'b1;
            endcase
         end
         ST_MULW: begin
            if (mul_done) begin
               if ((op_ff == OP_MUL) && !last_k) begin
                  cmd.acc_add = 1'b1;
                  k_in        = k_ff + IW'(1);
                  state_in    = ST_RD;
               end else begin
                  cmd.c_wr  = 1'b1;
                  cmd.c_src = (op_ff == OP_MUL) ? CSRC_MAC : CSRC_PROD;
                  adv       = 1'b1;
               end
            end
         end
         ST_FIN: begin
            cmd.eq_commit = (op_ff == OP_EQ);
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Step to the next element of C in row-major order.
      if (adv) begin
         k_in = '0;
         if (last_j) begin
            j_in = '0;
            if (last_i) begin
               state_in = ST_FIN;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_RD;
            end
         end else begin
            j_in     = j_ff + IW'(1);
            state_in = ST_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RESET;
         size_ff      <= SIZE_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         size_ff      <= size_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign idx_i     = i_ff;
   assign idx_j     = j_ff;
   assign idx_k     = k_ff;

endmodule

[src/square_matrix_arith_unit.sv]
// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+------------------------------------
// req_       | in        | req_valid/req_stall  | mode, row, col, value
// rsp_       | out       | rsp_valid/rsp_stall  | status, element, equal
// csr_       | in        | csr_wr_en            | csr_index, csr_wdata (no read-back)
//
// Element writes and reads pass through acceptance, then the response register load.
// A compute transaction walks the n x n element positions of the configured size,
// reading A and B, then operating on them; scalar and matrix multiply wait on the
// shared chunked multiplier, matrix multiply once per term of each sum, and each
// store has one read port. Unused operation codes go straight to the response.
// Reset is synchronous and active high; it clears the valid bits of all three stores,
// so no clearing pass is needed. A stalled response holds in its register while the
// next transaction is accepted; that transaction's response waits for the register.
module square_matrix_arith_unit
   import smau_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [IDX_W-1:0]          req_row,
   input  logic [IDX_W-1:0]          req_col,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_status,
   output logic signed [VALUE_W-1:0] rsp_element,
   output logic                      rsp_equal,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IW = idx_bits(MAX_DIM);

   // The controller sequences the element loops and the handshakes; the datapath
   // owns the stores, the multiplier, the accumulator and the response payload.
   smau_cmd_type  cmd;
   logic [IW-1:0] idx_i, idx_j, idx_k;
   logic          mul_done;

   smau_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_row   (req_row),
      .req_col   (req_col),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mul_done  (mul_done),
      .cmd       (cmd),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .idx_k     (idx_k)
   );

   // Writes of A and B and reads of C use the request's row and column at acceptance; a
   // computation walks the counters of the controller instead.
   smau_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .idx_i       (idx_i),
      .idx_j       (idx_j),
      .idx_k       (idx_k),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mul_done    (mul_done),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_equal   (rsp_equal)
   );

endmodule

[src/smau_checker.sv]
module smau_checker
   import smau_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_status,
   input logic signed [VALUE_W-1:0] rsp_element,
   input logic                      rsp_equal
);

   // One transaction at a time: an accepted request blocks the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a transaction was in flight");

   // An index error never carries element data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_element == '0))
      else $error("error response with nonzero element");

   // A response appears only at the end of a transaction in flight.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a transaction in flight");

   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_element) && $stable(rsp_equal)))
      else $error("stalled response changed");

endmodule

bind square_matrix_arith_unit smau_checker u_checker (.*);
